// ===== hw/rtl/unison_polyblep_saw_oscillator_defines.svh =====
// Assertion macros shared by the oscillator RTL
`ifndef UNISON_POLYBLEP_SAW_OSCILLATOR_DEFINES_SVH
`define UNISON_POLYBLEP_SAW_OSCILLATOR_DEFINES_SVH

// same-cycle implication, checked on every clk edge outside reset
`define UPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every clk edge outside reset
`define UPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ups_pkg.sv =====
// Constants and types for the unison polyBLEP sawtooth oscillator
package ups_pkg;

  localparam int MAX_VOICES = 5;
  localparam int PHASE_BITS = 32;
  localparam int VOICE_W    = $clog2(MAX_VOICES);
  localparam int CNT_W      = $clog2(MAX_VOICES + 1);
  localparam int SUM_W      = PHASE_BITS + 8;
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int OUT_W      = 16;
  localparam int OUT_SHIFT  = PHASE_BITS - (OUT_W - 1);
  localparam int RECIP_FRAC = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 3;

  localparam logic [PHASE_BITS-1:0] BLEP_WIDTH_RST = PHASE_BITS'(39370533);
  localparam logic [31:0]           BLEP_RECIP_RST = 32'd7149335;
  localparam logic [COUNT_W-1:0]    VOICE_COUNT_RST = COUNT_W'(1);
  localparam logic [PHASE_BITS-1:0] INCREMENT_RST  = PHASE_BITS'(39370533);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEP_WIDTH  = 3'd0,
    REG_BLEP_RECIP  = 3'd1,
    REG_VOICE_COUNT = 3'd2,
    REG_INC_ZERO    = 3'd3,
    REG_INC_ONE     = 3'd4,
    REG_INC_TWO     = 3'd5,
    REG_INC_THREE   = 3'd6,
    REG_INC_FOUR    = 3'd7
  } cfg_reg_t;

endpackage

// ===== hw/rtl/unison_polyblep_saw_oscillator.sv =====
// Unison polyBLEP sawtooth oscillator: sequencer, shared multiplier and divider
// Each accepted tick yields one Q1.15 sample, averaged over N active voices
// (N = 1..5): every voice passes in turn through one shared 32x32 multiplier
// (window position, then its square, then accumulate and phase advance), and
// the average is formed by a one-bit-per-cycle restoring divider over a 40-bit
// sum, with a prepare step, the divide steps and an output step in that order.
// The input is ready only while idle; a finished sample waits in an output
// register, so the next tick can be taken before the previous sample is
// transferred, and a sample that finishes while that register is still full
// holds the block until the transfer. The configuration port is always ready,
// and the user must see that it is written only while the block is idle; the
// block itself does not enforce this.
`include "unison_polyblep_saw_oscillator_defines.svh"

module unison_polyblep_saw_oscillator
  import ups_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      sample_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SQUARE,
    S_ACC,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  logic [PHASE_BITS-1:0]   blep_width;
  logic [31:0]             blep_recip;
  logic [COUNT_W-1:0]      voice_count;
  logic [PHASE_BITS-1:0]   increment [MAX_VOICES];
  logic [PHASE_BITS-1:0]   phase [MAX_VOICES];

  logic [VOICE_W-1:0]      voice;
  logic [CNT_W-1:0]        n_eff;
  logic                    near_zero;
  logic                    near_one;
  logic [2*PHASE_BITS-1:0] prod;
  logic [PHASE_BITS-1:0]   t_pos;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        div_quo;
  logic [CNT_W-1:0]        div_rem;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic                    div_sign;

  logic [PHASE_BITS-1:0]   p_cur;
  logic                    lt_width;
  logic [PHASE_BITS:0]     end_sum;
  logic                    gt_one;
  logic [PHASE_BITS-1:0]   win_dist;
  logic [PHASE_BITS-1:0]   t_clamp;
  logic [PHASE_BITS-1:0]   mul_a;
  logic [PHASE_BITS-1:0]   mul_b;
  logic [2*PHASE_BITS-1:0] mul_p;
  logic signed [SUM_W-1:0] p2_x;
  logic signed [SUM_W-1:0] t2_x;
  logic signed [SUM_W-1:0] tt_x;
  logic signed [SUM_W-1:0] one_x;
  logic signed [SUM_W-1:0] voice_val;
  logic [CNT_W:0]          rem_sh;
  logic                    rem_ge;
  logic [CNT_W:0]          rem_sub;
  logic signed [SUM_W-1:0] avg;
  logic signed [SUM_W-1:0] rounded;
  logic signed [SUM_W-1:0] shifted;
  logic signed [OUT_W-1:0] sat;
  logic [CNT_W-1:0]        n_sel;
  logic [VOICE_W-1:0]      inc_sel;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // voice datapath
  assign p_cur    = phase[voice];
  assign lt_width = (p_cur < blep_width);
  assign end_sum  = {1'b0, p_cur} + {1'b0, blep_width};
  assign gt_one   = (end_sum > {1'b1, {PHASE_BITS{1'b0}}});
  assign win_dist = lt_width ? p_cur : (~p_cur + PHASE_BITS'(1));

  assign t_clamp = (|prod[2*PHASE_BITS-1:PHASE_BITS+RECIP_FRAC]) ? {PHASE_BITS{1'b1}}
                 : prod[PHASE_BITS+RECIP_FRAC-1:RECIP_FRAC];

  assign mul_a = (state == S_LOAD) ? win_dist : t_clamp;
  assign mul_b = (state == S_LOAD) ? PHASE_BITS'(blep_recip) : t_clamp;
  assign mul_p = mul_a * mul_b;

  assign p2_x  = SUM_W'({p_cur, 1'b0});
  assign t2_x  = SUM_W'(prod[2*PHASE_BITS-1:PHASE_BITS]);
  assign tt_x  = SUM_W'({t_pos, 1'b0});
  assign one_x = SUM_W'({1'b1, {PHASE_BITS{1'b0}}});

  always_comb begin
    if (near_zero) begin
      voice_val = p2_x - tt_x + t2_x;
    end else if (near_one) begin
      voice_val = p2_x - (one_x <<< 1) - t2_x + tt_x;
    end else begin
      voice_val = p2_x - one_x;
    end
  end

  // divider step
  assign rem_sh  = {div_rem, div_quo[SUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, n_eff});
  assign rem_sub = rem_sh - {1'b0, n_eff};

  // rounding and saturation
  assign avg     = div_sign ? -$signed(div_quo) : $signed(div_quo);
  assign rounded = avg + (SUM_W'(1) <<< (OUT_SHIFT - 1));
  assign shifted = rounded >>> OUT_SHIFT;

  always_comb begin
    if (shifted > SUM_W'(2**(OUT_W-1) - 1)) begin
      sat = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (shifted < -(SUM_W'(2**(OUT_W-1)))) begin
      sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat = shifted[OUT_W-1:0];
    end
  end

  always_comb begin
    if (voice_count == '0) begin
      n_sel = CNT_W'(1);
    end else if (CNT_W'(voice_count) > CNT_W'(MAX_VOICES)) begin
      n_sel = CNT_W'(MAX_VOICES);
    end else begin
      n_sel = CNT_W'(voice_count);
    end
  end

  assign inc_sel = VOICE_W'(cfg_index - REG_INC_ZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      blep_width  <= BLEP_WIDTH_RST;
      blep_recip  <= BLEP_RECIP_RST;
      voice_count <= VOICE_COUNT_RST;
      for (int i = 0; i < MAX_VOICES; i++) begin
        increment[i] <= INCREMENT_RST;
        phase[i]     <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLEP_WIDTH:  blep_width  <= cfg_data[PHASE_BITS-1:0];
          REG_BLEP_RECIP:  blep_recip  <= cfg_data[31:0];
          REG_VOICE_COUNT: voice_count <= cfg_data[COUNT_W-1:0];
          default: begin
            if (cfg_index inside {[REG_INC_ZERO:REG_INC_FOUR]} &&
                (int'(cfg_index) - int'(REG_INC_ZERO)) < MAX_VOICES) begin
              increment[inc_sel] <= cfg_data[PHASE_BITS-1:0];
            end
          end
        endcase
      end

      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              for (int i = 0; i < MAX_VOICES; i++) begin
                phase[i] <= '0;
              end
            end
            n_eff <= n_sel;
            voice <= '0;
            sum   <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          near_zero <= lt_width;
          near_one  <= !lt_width && gt_one;
          prod      <= mul_p;
          state     <= S_SQUARE;
        end
        S_SQUARE: begin
          t_pos <= t_clamp;
          prod  <= mul_p;
          state <= S_ACC;
        end
        S_ACC: begin
          sum          <= sum + voice_val;
          phase[voice] <= p_cur + increment[voice];
          if (CNT_W'(voice) == n_eff - CNT_W'(1)) begin
            state <= S_PREP;
          end else begin
            voice <= voice + VOICE_W'(1);
            state <= S_LOAD;
          end
        end
        S_PREP: begin
          div_sign <= sum[SUM_W-1];
          div_quo  <= sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
          div_rem  <= '0;
          div_cnt  <= DIV_CNT_W'(SUM_W - 1);
          state    <= S_DIV;
        end
        S_DIV: begin
          div_rem <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          div_quo <= {div_quo[SUM_W-2:0], rem_ge};
          if (div_cnt == '0) begin
            state <= S_DONE;
          end else begin
            div_cnt <= div_cnt - DIV_CNT_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            sample_out <= sat;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `UPS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `UPS_ASSERT_NOW(a_voice_in_range,
    state == S_LOAD || state == S_SQUARE || state == S_ACC,
    CNT_W'(voice) < n_eff, "voice index beyond active count")
  `UPS_ASSERT_NEXT(a_restart_zeroes, in_valid && in_ready && restart,
    phase[0] == '0, "restart did not clear phase")
  `UPS_ASSERT_NOW(a_out_from_done, $rose(out_valid),
    $past(state) == S_DONE, "output raised outside final step")
  `UPS_ASSERT_NOW(a_count_legal, state != S_IDLE,
    n_eff != '0 && n_eff <= CNT_W'(MAX_VOICES), "active count out of range")

endmodule

// ===== verif/ups_checker.sv =====
// Checker for the unison polyBLEP saw oscillator: predicts each sample and compares transfers
module ups_checker
  import ups_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         restart,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [OUT_W-1:0]      sample_out,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  output int                           errors,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] PH_ONE  = 64'd1 << PHASE_BITS;
  localparam logic [63:0] PH_MASK = PH_ONE - 64'd1;
  localparam longint      ONE_S   = longint'(PH_ONE);

  logic [PHASE_BITS-1:0]   win_width;
  logic [31:0]             win_recip;
  logic [COUNT_W-1:0]      voice_cnt;
  logic [PHASE_BITS-1:0]   inc [MAX_VOICES];
  logic [PHASE_BITS-1:0]   phase [MAX_VOICES];
  logic signed [OUT_W-1:0] sample_q [$];
  int                      mismatches;

  function automatic logic [63:0] window_pos(input logic [63:0] span);
    logic [63:0] t;
    t = (span * 64'(win_recip)) >> RECIP_FRAC;
    if (t > PH_MASK) begin
      t = PH_MASK;
    end
    return t;
  endfunction

  function automatic longint frac_square(input logic [63:0] t);
    logic [63:0] sq;
    sq = (t * t) >> PHASE_BITS;
    return longint'(sq);
  endfunction

  function automatic longint blep_offset(input logic [63:0] p);
    logic [63:0] u;
    longint      t;
    if (p < 64'(win_width)) begin
      u = window_pos(p);
      t = longint'(u);
      return 2 * t - frac_square(u) - ONE_S;
    end
    if (p + 64'(win_width) > PH_ONE) begin
      u = window_pos(PH_ONE - p);
      t = longint'(u);
      return frac_square(u) - 2 * t + ONE_S;
    end
    return 0;
  endfunction

  function automatic logic signed [OUT_W-1:0] next_saw_sample(input logic clear);
    int          n;
    longint      sum;
    longint      avg;
    longint      res;
    logic [63:0] p;
    n = (voice_cnt == 0) ? 1 : (voice_cnt > MAX_VOICES) ? MAX_VOICES : int'(voice_cnt);
    if (clear) begin
      for (int v = 0; v < MAX_VOICES; v++) begin
        phase[v] = '0;
      end
    end
    sum = 0;
    for (int v = 0; v < n; v++) begin
      p = 64'(phase[v]);
      sum += 2 * longint'(p) - ONE_S - blep_offset(p);
      phase[v] = phase[v] + inc[v];
    end
    avg = sum / longint'(n);
    res = (avg + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (res > 32767) begin
      res = 32767;
    end else if (res < -32768) begin
      res = -32768;
    end
    return res[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic signed [OUT_W-1:0] want;
    if (rst) begin
      win_width = BLEP_WIDTH_RST;
      win_recip = BLEP_RECIP_RST;
      voice_cnt = VOICE_COUNT_RST;
      for (int v = 0; v < MAX_VOICES; v++) begin
        inc[v]   = INCREMENT_RST;
        phase[v] = '0;
      end
      sample_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sample_q.size() == 0) begin
          $error("sample_out: expected none, actual %0d", sample_out);
          mismatches++;
        end else begin
          want = sample_q.pop_front();
          if (sample_out !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, sample_out);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_BLEP_WIDTH:  win_width = cfg_data[PHASE_BITS-1:0];
          REG_BLEP_RECIP:  win_recip = cfg_data;
          REG_VOICE_COUNT: voice_cnt = cfg_data[COUNT_W-1:0];
          REG_INC_ZERO:    inc[0] = cfg_data[PHASE_BITS-1:0];
          REG_INC_ONE:     inc[1] = cfg_data[PHASE_BITS-1:0];
          REG_INC_TWO:     inc[2] = cfg_data[PHASE_BITS-1:0];
          REG_INC_THREE:   inc[3] = cfg_data[PHASE_BITS-1:0];
          REG_INC_FOUR:    inc[4] = cfg_data[PHASE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        sample_q.push_back(next_saw_sample(restart));
      end
    end
    errors      <= mismatches;
    outstanding <= sample_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the unison polyBLEP saw oscillator: stimulus, flow control and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ups_pkg::*;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_TICKS  = 128;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_RECEIVER_STALL,
    FLOW_BOTH
  } flow_mode_t;

  typedef struct packed {
    logic [31:0]                 width;
    logic [31:0]                 recip;
    logic [31:0]                 count;
    logic [MAX_VOICES-1:0][31:0] inc;
  } osc_setting_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic                    restart   = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] sample_out;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  int                      errors;
  int                      outstanding;
  int                      cycle_cnt   = 0;
  int                      idle_pct    = 0;
  int                      stall_pct   = 0;
  int                      tick_cnt    = 0;
  int                      restart_cnt = 0;
  int                      setting_cnt = 0;

  unison_polyblep_saw_oscillator u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ups_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic osc_setting_t make_setting(input logic [31:0] width, recip, count,
                                                 i0, i1, i2, i3, i4);
    osc_setting_t s;
    s.width  = width;
    s.recip  = recip;
    s.count  = count;
    s.inc[0] = i0;
    s.inc[1] = i1;
    s.inc[2] = i2;
    s.inc[3] = i3;
    s.inc[4] = i4;
    return s;
  endfunction

  function automatic osc_setting_t rand_setting();
    osc_setting_t s;
    logic [31:0]  spread;
    logic [63:0]  q;
    int           style;
    style   = $urandom_range(9);
    s.width = $urandom_range(32'h8000_0000, 1) >> $urandom_range(24);
    if (s.width == 0) begin
      s.width = 1;
    end
    if (style == 0) begin
      s.width = $urandom();
    end else if (style == 1) begin
      s.width = '0;
    end
    if (s.width == 0 || style == 2) begin
      s.recip = $urandom();
    end else begin
      q       = (64'd1 << 48) / 64'(s.width);
      s.recip = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    s.count = $urandom();
    spread  = (s.width >> 5) + 1;
    for (int v = 0; v < MAX_VOICES; v++) begin
      if (style == 3) begin
        s.inc[v] = $urandom();
      end else begin
        s.inc[v] = s.width - (spread >> 1) + ($urandom() % spread);
      end
    end
    return s;
  endfunction

  task automatic set_mode(input flow_mode_t m);
    case (m)
      FLOW_FREE: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      FLOW_SENDER_IDLE: begin
        idle_pct = 85;
        stall_pct <= 0;
      end
      FLOW_RECEIVER_STALL: begin
        idle_pct = 0;
        stall_pct <= 85;
      end
      default: begin
        idle_pct = 24;
        stall_pct <= 24;
      end
    endcase
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drain the stream, then load every register back to back
  task automatic apply_setting(input osc_setting_t s);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    put_reg(REG_BLEP_WIDTH, s.width);
    put_reg(REG_BLEP_RECIP, s.recip);
    put_reg(REG_VOICE_COUNT, s.count);
    put_reg(REG_INC_ZERO, s.inc[0]);
    put_reg(REG_INC_ONE, s.inc[1]);
    put_reg(REG_INC_TWO, s.inc[2]);
    put_reg(REG_INC_THREE, s.inc[3]);
    put_reg(REG_INC_FOUR, s.inc[4]);
    cfg_valid <= 1'b0;
    setting_cnt++;
  endtask

  task automatic send_tick(input logic r);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    restart  <= r;
    do @(posedge clk); while (!in_ready);
    tick_cnt++;
    restart_cnt += r;
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_mode(FLOW_FREE);

    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    apply_setting(make_setting(32'h8000_0000, 32'h0001_0000, 32'd5, 32'd0, 32'h8000_0000,
                               32'd1, 32'hFFFF_FFFF, 32'h0255_0000));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);

    apply_setting(make_setting(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    apply_setting(make_setting(32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    apply_setting(make_setting(32'hFFFF_FFFF, 32'h0002_0000, 32'd3, 32'h5555_5555,
                               32'hAAAA_AAAA, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F));
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    apply_setting(make_setting(BLEP_WIDTH_RST, BLEP_RECIP_RST, 32'd5, 32'h0400_0000,
                               32'h03FF_0000, 32'h0401_0000, 32'h0000_0000, 32'h0800_0000));
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_setting(rand_setting());
      set_mode(flow_mode_t'(p % 4));
      for (int k = 0; k < PHASE_TICKS; k++) begin
        send_tick($urandom_range(99) < 4);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d ticks (%0d with phase restart) over %0d register settings",
             tick_cnt, restart_cnt, setting_cnt);
    $display("Flow control ran free, with sender gaps, receiver stalls and both mixed");
    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ups_pkg.sv
hw/rtl/unison_polyblep_saw_oscillator.sv
verif/ups_checker.sv
verif/tb_top.sv
